@@ hdl/srsw_pkg.sv @@
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and codes of the selective repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int ACT_W     = 2;
  localparam int SEQ_W     = 4;
  localparam int TAG_W     = 32;
  localparam int WIN_W     = 4;
  localparam int WIN_RESET = 4;

  localparam logic [ACT_W-1:0] ACT_SEND    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ACK     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [SEQ_W-1:0] seq_num;
    logic             checksum_ok;
    logic [TAG_W-1:0] payload_tag;
  } srsw_in_t;

  typedef struct packed {
    logic             accepted;
    logic             tx_valid;
    logic [SEQ_W-1:0] tx_seq;
    logic [TAG_W-1:0] tx_payload_tag;
    logic             timer_start;
    logic             timer_stop;
    logic [SEQ_W-1:0] timer_seq;
    logic             window_full;
  } srsw_out_t;

endpackage

@@ hdl/srsw_if.sv @@
// ----------------------------------------------------------------------------
// srsw_if
// Valid/ready channels for the event input and the result output.
// ----------------------------------------------------------------------------
interface srsw_in_if;
  logic               valid;
  logic               ready;
  srsw_pkg::srsw_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface srsw_out_if;
  logic                valid;
  logic                ready;
  srsw_pkg::srsw_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/selective_repeat_sender_window_unit.sv @@
// Sequencing: every event steps through the calc, address, exec and finish states; an ack
//   that hits also passes the slide state, which walks the acked flags one slot a cycle.
// The result is registered in the finish step, and a new event is taken only in idle, so one
//   event is done before the next is taken. The tag memory is one-port, and a held result
//   stalls the sequencer in its finish step.
// Reset: synchronous, active low; window empty, sequence numbers zero, window size 4.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_unit
// Sender window of selective repeat ARQ: numbers and stores new packets,
// processes acks with window slide, and retransmits on timer expiry.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_unit #(
  parameter int SEQ_BITS   = 4,
  parameter int MAX_WINDOW = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [srsw_pkg::WIN_W-1:0] cfg_wdata,
  srsw_in_if.sink                    in_if,
  srsw_out_if.source                 out_if
);
  import srsw_pkg::*;

  localparam int SEQ_SPACE = 1 << SEQ_BITS;
  localparam int CAP       = (MAX_WINDOW < SEQ_SPACE) ? MAX_WINDOW : SEQ_SPACE;
  localparam int CNT_W     = $clog2(CAP + 1);
  localparam int SLOT_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int EW        = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int CW        = (SEQ_BITS > CNT_W) ? SEQ_BITS : CNT_W;
  localparam int AW        = ((SLOT_W > CW) ? SLOT_W : CW) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_SLIDE = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_SEND = 2'd1;
  localparam logic [1:0] K_STOP = 2'd2;
  localparam logic [1:0] K_RETX = 2'd3;

  logic [2:0]            state_r, state_nxt;
  logic [WIN_W-1:0]      win_r, win_nxt;
  logic [SEQ_BITS-1:0]   next_seq_r, next_seq_nxt;
  logic [SEQ_BITS-1:0]   base_r, base_nxt;
  logic [SLOT_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]      outst_r, outst_nxt;
  logic [MAX_WINDOW-1:0] marks_r, marks_nxt;
  logic                  waiting_r, waiting_nxt;

  logic [ACT_W-1:0]      act_r, act_nxt;
  logic [SEQ_BITS-1:0]   seq_r, seq_nxt;
  logic                  ck_r, ck_nxt;
  logic [TAG_W-1:0]      tag_r, tag_nxt;
  logic [SEQ_BITS-1:0]   off_r, off_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic [SEQ_BITS-1:0]   res_seq_r, res_seq_nxt;
  logic [TAG_W-1:0]      rd_data_r;

  logic                  out_valid_r, out_valid_nxt;
  srsw_out_t             out_data_r, out_data_nxt;

  logic [TAG_W-1:0]      tag_mem [MAX_WINDOW];
  logic                  mem_we;

  logic [EW-1:0]         eff_win;
  logic [EW-1:0]         win_ext;
  logic [CNT_W-1:0]      outst_inc;
  logic                  hit;
  logic [AW-1:0]         slot_sum;
  logic [AW-1:0]         slot_wrap;
  logic                  is_tx;

  always_comb begin
    win_ext = EW'(win_r);
    if (win_ext == '0) begin
      eff_win = EW'(1);
    end else if (win_ext > EW'(CAP)) begin
      eff_win = EW'(CAP);
    end else begin
      eff_win = win_ext;
    end
  end

  assign outst_inc = outst_r + CNT_W'(1);
  assign hit       = CW'(off_r) < CW'(outst_r);
  assign slot_sum  = AW'(head_r) + ((act_r == ACT_SEND) ? AW'(outst_r) : AW'(off_r));
  assign slot_wrap = (slot_sum >= AW'(MAX_WINDOW)) ? slot_sum - AW'(MAX_WINDOW) : slot_sum;
  assign is_tx     = (kind_r == K_SEND) || (kind_r == K_RETX);

  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    next_seq_nxt  = next_seq_r;
    base_nxt      = base_r;
    head_nxt      = head_r;
    outst_nxt     = outst_r;
    marks_nxt     = marks_r;
    waiting_nxt   = waiting_r;
    act_nxt       = act_r;
    seq_nxt       = seq_r;
    ck_nxt        = ck_r;
    tag_nxt       = tag_r;
    off_nxt       = off_r;
    slot_nxt      = slot_r;
    kind_nxt      = kind_r;
    res_seq_nxt   = res_seq_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;

    if (cfg_we) begin
      win_nxt = cfg_wdata;
    end
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          act_nxt   = in_if.data.action;
          seq_nxt   = SEQ_BITS'(in_if.data.seq_num);
          ck_nxt    = in_if.data.checksum_ok;
          tag_nxt   = in_if.data.payload_tag;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        off_nxt   = seq_r - base_r;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        slot_nxt  = SLOT_W'(slot_wrap);
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        kind_nxt    = K_NONE;
        res_seq_nxt = seq_r;
        state_nxt   = S_FIN;
        case (act_r)
          ACT_SEND: begin
            if (!waiting_r && (outst_r < CNT_W'(CAP))) begin
              mem_we            = 1'b1;
              marks_nxt[slot_r] = 1'b0;
              outst_nxt         = outst_inc;
              kind_nxt          = K_SEND;
              res_seq_nxt       = next_seq_r;
              next_seq_nxt      = next_seq_r + SEQ_BITS'(1);
              if (EW'(outst_inc) >= eff_win) begin
                waiting_nxt = 1'b1;
              end
            end
          end
          ACT_ACK: begin
            if ((outst_r != '0) && ck_r && hit) begin
              marks_nxt[slot_r] = 1'b1;
              kind_nxt          = K_STOP;
              state_nxt         = S_SLIDE;
            end
          end
          ACT_TIMEOUT: begin
            if ((outst_r != '0) && hit) begin
              kind_nxt = K_RETX;
            end
          end
          default: ;
        endcase
      end
      S_SLIDE: begin
        if ((outst_r != '0) && marks_r[head_r]) begin
          marks_nxt[head_r] = 1'b0;
          head_nxt  = (head_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : head_r + SLOT_W'(1);
          base_nxt  = base_r + SEQ_BITS'(1);
          outst_nxt = outst_r - CNT_W'(1);
        end else begin
          if (EW'(outst_r) < eff_win) begin
            waiting_nxt = 1'b0;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.accepted       = (kind_r == K_SEND);
          out_data_nxt.tx_valid       = is_tx;
          out_data_nxt.tx_seq         = is_tx ? SEQ_W'(res_seq_r) : '0;
          out_data_nxt.tx_payload_tag = (kind_r == K_SEND) ? tag_r :
                                        (kind_r == K_RETX) ? rd_data_r : '0;
          out_data_nxt.timer_start    = is_tx;
          out_data_nxt.timer_stop     = (kind_r == K_STOP);
          out_data_nxt.timer_seq      = (kind_r != K_NONE) ? SEQ_W'(res_seq_r) : '0;
          out_data_nxt.window_full    = waiting_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= WIN_W'(WIN_RESET);
      next_seq_r  <= '0;
      base_r      <= '0;
      head_r      <= '0;
      outst_r     <= '0;
      marks_r     <= '0;
      waiting_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      next_seq_r  <= next_seq_nxt;
      base_r      <= base_nxt;
      head_r      <= head_nxt;
      outst_r     <= outst_nxt;
      marks_r     <= marks_nxt;
      waiting_r   <= waiting_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    seq_r      <= seq_nxt;
    ck_r       <= ck_nxt;
    tag_r      <= tag_nxt;
    off_r      <= off_nxt;
    slot_r     <= slot_nxt;
    kind_r     <= kind_nxt;
    res_seq_r  <= res_seq_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[slot_r] <= tag_r;
    end
    rd_data_r <= tag_mem[slot_r];
  end

  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  a_outst_cap: assert property (@(posedge clk) disable iff (!rst_n)
    outst_r <= CNT_W'(CAP))
    else $error("outstanding count above ring capacity");

  a_wait_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (waiting_r && (state_r != S_SLIDE)) |-> (outst_r != '0))
    else $error("waiting with an empty window");

  a_seq_span: assert property (@(posedge clk) disable iff (!rst_n)
    SEQ_BITS'(next_seq_r - base_r) == SEQ_BITS'(outst_r))
    else $error("sequence span disagrees with outstanding count");

  a_marks_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (outst_r == '0) |-> (marks_r == '0))
    else $error("acked flag left set in an empty window");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside the finish step");

endmodule

@@ sim/tb_selective_repeat_sender_window_unit.sv @@
// ----------------------------------------------------------------------------
// tb_selective_repeat_sender_window_unit
// Self-checking bench for the selective repeat sender window. Events are
// driven on the input channel with random gaps, and every response is compared
// field by field against a window tracker kept inside the bench. Directed
// tests cover empty-window events, fill and refusal, ack marking and sliding,
// retransmission and window register changes. Random traffic under several
// window settings, including out-of-range ones, follows, together with
// back-to-back and output backpressure runs.
// ----------------------------------------------------------------------------
module tb_selective_repeat_sender_window_unit;
  import srsw_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int RING_SLOTS     = 8;
  localparam int PHASE_ITEMS    = 117;
  localparam int EXP_DEPTH      = 16;
  localparam int RX_HOLD_CYCLES = 150;
  localparam logic [ACT_W-1:0] ACT_UNDEFINED = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_wdata;

  srsw_in_if  in_ch ();
  srsw_out_if out_ch ();

  selective_repeat_sender_window_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  // window tracker
  logic [WIN_W-1:0] win_reg;
  logic [SEQ_W-1:0] next_seq;
  logic [SEQ_W-1:0] base_seq;
  logic [2:0]       head_slot;
  logic [3:0]       outstanding;
  logic             acked_mark [RING_SLOTS];
  logic [TAG_W-1:0] slot_tag [RING_SLOTS];
  logic             waiting;

  srsw_out_t  expected_ring [EXP_DEPTH];
  logic [3:0] exp_wr_ptr = '0;
  logic [3:0] exp_rd_ptr = '0;
  srsw_out_t  last_prediction;

  logic no_gaps      = 1'b0;
  logic hold_request = 1'b0;
  logic rx_hold      = 1'b0;
  int   cycle_count  = 0;
  int   errors       = 0;
  int   n_expected   = 0;
  int   n_checked    = 0;
  int   n_accepted   = 0;
  int   n_refused    = 0;
  int   n_stops      = 0;
  int   n_retx       = 0;
  int   n_cfg_writes = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [3:0] effective_window();
    logic [3:0] w;
    w = win_reg;
    if (w < 4'd1) w = 4'd1;
    if (w > 4'(RING_SLOTS)) w = 4'(RING_SLOTS);
    return w;
  endfunction

  function automatic srsw_out_t compute_sender_response(srsw_in_t ev);
    srsw_out_t        res;
    logic [SEQ_W-1:0] off;
    logic [2:0]       slot;
    res = '0;
    off = ev.seq_num - base_seq;
    case (ev.action)
      ACT_SEND: begin
        if (!waiting && outstanding < RING_SLOTS) begin
          slot = head_slot + outstanding[2:0];
          slot_tag[slot]     = ev.payload_tag;
          acked_mark[slot]   = 1'b0;
          outstanding        = outstanding + 4'd1;
          res.accepted       = 1'b1;
          res.tx_valid       = 1'b1;
          res.tx_seq         = next_seq;
          res.tx_payload_tag = ev.payload_tag;
          res.timer_start    = 1'b1;
          res.timer_seq      = next_seq;
          if (outstanding >= effective_window()) waiting = 1'b1;
          next_seq = next_seq + 4'd1;
        end
      end
      ACT_ACK: begin
        if (outstanding != 0 && ev.checksum_ok && off < outstanding) begin
          acked_mark[head_slot + off[2:0]] = 1'b1;
          res.timer_stop = 1'b1;
          res.timer_seq  = ev.seq_num;
          while (outstanding != 0 && acked_mark[head_slot]) begin
            acked_mark[head_slot] = 1'b0;
            head_slot   = head_slot + 3'd1;
            base_seq    = base_seq + 4'd1;
            outstanding = outstanding - 4'd1;
          end
          if (outstanding < effective_window()) waiting = 1'b0;
        end
      end
      ACT_TIMEOUT: begin
        if (outstanding != 0 && off < outstanding) begin
          res.tx_valid       = 1'b1;
          res.tx_seq         = ev.seq_num;
          res.tx_payload_tag = slot_tag[head_slot + off[2:0]];
          res.timer_start    = 1'b1;
          res.timer_seq      = ev.seq_num;
        end
      end
      default: begin
      end
    endcase
    res.window_full = waiting;
    return res;
  endfunction

  function automatic srsw_in_t make_event(logic [ACT_W-1:0] act, logic [SEQ_W-1:0] seq,
                                          logic ck, logic [TAG_W-1:0] tag);
    srsw_in_t ev;
    ev.action      = act;
    ev.seq_num     = seq;
    ev.checksum_ok = ck;
    ev.payload_tag = tag;
    return ev;
  endfunction

  function automatic srsw_in_t random_event();
    int               pick;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] off_pick;
    logic [SEQ_W-1:0] in_window;
    logic [TAG_W-1:0] tag;
    pick = $urandom_range(0, 99);
    seq  = SEQ_W'($urandom_range(0, 15));
    tag  = $urandom;
    if ($urandom_range(0, 9) == 0) tag = $urandom_range(0, 1) ? '1 : '0;
    in_window = seq;
    if (outstanding != 0) begin
      off_pick  = ($urandom_range(0, 9) < 4) ? '0 :
                  SEQ_W'($urandom_range(0, outstanding - 1));
      in_window = base_seq + off_pick;
    end
    if (pick < 40) return make_event(ACT_SEND, seq, 1'($urandom_range(0, 1)), tag);
    if (pick < 68) return make_event(ACT_ACK, in_window, $urandom_range(0, 9) != 0, tag);
    if (pick < 86) return make_event(ACT_TIMEOUT, in_window, 1'($urandom_range(0, 1)), tag);
    if (pick < 91) return make_event(ACT_ACK, seq, 1'($urandom_range(0, 1)), tag);
    if (pick < 96) return make_event(ACT_TIMEOUT, seq, 1'($urandom_range(0, 1)), tag);
    return make_event(ACT_UNDEFINED, seq, 1'($urandom_range(0, 1)), tag);
  endfunction

  task automatic report_error(string msg);
    errors++;
    $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string name, logic [TAG_W-1:0] got, logic [TAG_W-1:0] want);
    if (got !== want) begin
      report_error($sformatf("response %0d %s got 0x%0h want 0x%0h",
                             n_checked, name, got, want));
    end
  endtask

  task automatic check_response(srsw_out_t got);
    srsw_out_t want;
    if (n_expected == n_checked) begin
      report_error("response with no pending event");
      return;
    end
    want       = expected_ring[exp_rd_ptr];
    exp_rd_ptr = exp_rd_ptr + 4'd1;
    check_field("accepted", TAG_W'(got.accepted), TAG_W'(want.accepted));
    check_field("tx_valid", TAG_W'(got.tx_valid), TAG_W'(want.tx_valid));
    check_field("tx_seq", TAG_W'(got.tx_seq), TAG_W'(want.tx_seq));
    check_field("tx_payload_tag", got.tx_payload_tag, want.tx_payload_tag);
    check_field("timer_start", TAG_W'(got.timer_start), TAG_W'(want.timer_start));
    check_field("timer_stop", TAG_W'(got.timer_stop), TAG_W'(want.timer_stop));
    check_field("timer_seq", TAG_W'(got.timer_seq), TAG_W'(want.timer_seq));
    check_field("window_full", TAG_W'(got.window_full), TAG_W'(want.window_full));
    n_checked++;
  endtask

  // long receiver hold-off, counted here once the pressure test asks for it
  always begin
    wait (hold_request);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
    wait (!hold_request);
  end

  // response receiver: random stalls, hold off while rx_hold is set
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_response(out_ch.data);
    if (rx_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic send_event(srsw_in_t ev);
    int gap;
    if (!no_gaps && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= ev;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    last_prediction           = compute_sender_response(ev);
    expected_ring[exp_wr_ptr] = last_prediction;
    exp_wr_ptr                = exp_wr_ptr + 4'd1;
    n_expected++;
    if (ev.action == ACT_SEND) begin
      if (last_prediction.accepted) n_accepted++;
      else n_refused++;
    end
    if (last_prediction.timer_stop) n_stops++;
    if (last_prediction.tx_valid && !last_prediction.accepted) n_retx++;
  endtask

  task automatic wait_drained();
    while (n_expected != n_checked) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(logic [WIN_W-1:0] value);
    in_ch.valid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    win_reg = value;
    n_cfg_writes++;
  endtask

  task automatic test_empty_window();
    send_event(make_event(ACT_TIMEOUT, 4'd0, 1'b1, 32'h0));
    send_event(make_event(ACT_ACK, 4'd0, 1'b1, 32'h0));
    send_event(make_event(ACT_UNDEFINED, 4'hF, 1'b1, 32'hFFFF_FFFF));
  endtask

  task automatic test_fill_window();
    send_event(make_event(ACT_SEND, 4'h0, 1'b0, 32'h0000_0000));
    send_event(make_event(ACT_SEND, 4'hF, 1'b1, 32'hFFFF_FFFF));
    send_event(make_event(ACT_SEND, 4'h5, 1'b0, 32'hA5A5_A5A5));
    send_event(make_event(ACT_SEND, 4'hA, 1'b1, 32'h5A5A_5A5A));
    send_event(make_event(ACT_SEND, 4'h0, 1'b0, 32'h1234_5678));
  endtask

  task automatic test_ack_and_retransmit();
    send_event(make_event(ACT_ACK, 4'd2, 1'b0, 32'h0));
    send_event(make_event(ACT_ACK, 4'd9, 1'b1, 32'h0));
    send_event(make_event(ACT_ACK, 4'd2, 1'b1, 32'h0));
    send_event(make_event(ACT_ACK, 4'd2, 1'b1, 32'h0));
    send_event(make_event(ACT_TIMEOUT, 4'd2, 1'b0, 32'h0));
    send_event(make_event(ACT_TIMEOUT, 4'd15, 1'b1, 32'h0));
    send_event(make_event(ACT_TIMEOUT, 4'd1, 1'b1, 32'h0));
    send_event(make_event(ACT_ACK, 4'd0, 1'b1, 32'h0));
    send_event(make_event(ACT_ACK, 4'd1, 1'b1, 32'h0));
  endtask

  task automatic test_window_register();
    write_window(4'd1);
    send_event(make_event(ACT_SEND, 4'h3, 1'b1, 32'hC3C3_C3C3));
    send_event(make_event(ACT_SEND, 4'h3, 1'b1, 32'h3C3C_3C3C));
    write_window(4'd15);
    send_event(make_event(ACT_SEND, 4'h0, 1'b0, 32'h0F0F_0F0F));
    send_event(make_event(ACT_ACK, 4'd3, 1'b1, 32'h0));
    write_window(4'd0);
    send_event(make_event(ACT_ACK, 4'd4, 1'b1, 32'h0));
    send_event(make_event(ACT_SEND, 4'h0, 1'b0, 32'h8000_0001));
    write_window(4'd8);
    send_event(make_event(ACT_ACK, 4'd5, 1'b1, 32'h0));
  endtask

  task automatic test_output_backpressure();
    logic [SEQ_W-1:0] first;
    write_window(4'd8);
    first = next_seq;
    hold_request = 1'b1;
    repeat (8) send_event(make_event(ACT_SEND, 4'h0, 1'b0, $urandom));
    for (int i = 0; i < 8; i++) begin
      send_event(make_event(ACT_TIMEOUT, first + i[SEQ_W-1:0], 1'b1, 32'h0));
    end
    hold_request = 1'b0;
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (150) send_event(random_event());
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [WIN_W-1:0] settings [9] = '{4'd2, 4'd8, 4'd1, 4'd15, 4'd0, 4'd6, 4'd11, 4'd4, 4'd3};
    foreach (settings[p]) begin
      write_window(settings[p]);
      repeat (PHASE_ITEMS) send_event(random_event());
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    win_reg     = WIN_RESET;
    next_seq    = '0;
    base_seq    = '0;
    head_slot   = '0;
    outstanding = '0;
    waiting     = 1'b0;
    foreach (acked_mark[i]) begin
      acked_mark[i] = 1'b0;
      slot_tag[i]   = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_window();
    test_fill_window();
    test_ack_and_retransmit();
    test_window_register();
    test_output_backpressure();
    test_back_to_back();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Checked %0d responses: %0d sends taken, %0d refused, %0d timer stops,",
             n_checked, n_accepted, n_refused, n_stops);
    $display("%0d retransmits, %0d window register writes, %0d errors.",
             n_retx, n_cfg_writes, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
